// ===== src/i2cmts_pkg.sv =====
// Shared types and codes for the I2C master transaction sequencer.
package i2cmts_pkg;

  // op codes of an input word
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;

  // engine event codes
  localparam logic [2:0] EV_BUS_FREE   = 3'd0;
  localparam logic [2:0] EV_START_SENT = 3'd1;
  localparam logic [2:0] EV_TX_EMPTY   = 3'd2;
  localparam logic [2:0] EV_ADDR_ACKED = 3'd3;
  localparam logic [2:0] EV_ACK_FAILED = 3'd4;
  localparam logic [2:0] EV_RX_READY   = 3'd5;

  // result command codes
  localparam logic [2:0] CMD_START   = 3'd0;
  localparam logic [2:0] CMD_STOP    = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_ACK_ON  = 3'd3;
  localparam logic [2:0] CMD_ACK_OFF = 3'd4;
  localparam logic [2:0] CMD_RECV    = 3'd5;

  // 10-bit addressing header
  localparam logic [7:0] HDR_10      = 8'b1111_0000;
  localparam logic [2:0] HDR_HI_MASK = 3'b110;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic [3:0]  tx_slot;
    logic [9:0]  target_address;
    logic        ten_bit_mode;
    logic [4:0]  write_count;
    logic [15:0] read_count;
    logic [2:0]  event_code;
  } in_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] command_byte;
    logic       finished;
    logic       succeeded;
    logic       last_of_run;
  } out_t;

  typedef enum logic [1:0] {
    K_LOAD,
    K_BEGIN,
    K_EVENT
  } kind_e;

  // classified word handed from front to engine
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [3:0]  tx_slot;
    logic [9:0]  addr;
    logic        ten;
    logic [4:0]  wcount;
    logic [15:0] rcount;
    logic [2:0]  evt;
  } word_t;

  // all results caused by one word
  typedef struct packed {
    logic [1:0]     count;
    out_t [2:0]     res;
  } bundle_t;

endpackage

// ===== src/i2c_master_transaction_sequencer.sv =====
// Top level of the I2C master write-then-read transaction sequencer.
//
// Input words arrive on push/full: op selects a transmit byte load, a begin
// (address, 7/10-bit mode, write and read counts) or an event reported by the
// byte-level I2C engine. Results leave on empty/pop as engine commands (start,
// stop, write byte, ack on/off) and received bytes; finished/succeeded mark the
// end of a transaction and last_of_run the last result caused by one input.
// An accepted word is classified into a 2-entry queue, handled from there by
// the state machine, and its results are registered in the result queue
// before they reach the ports. One input word per cycle is sustained while
// the result queue has room; a word with three results holds the result port
// for three pops; the queues on each side keep taking input while those wait.
// If pop stays low the result queue fills and then full rises; nothing is
// dropped. Reset returns the sequencer to idle and empties both queues; the
// transmit store is not cleared and a slot is undefined until it is loaded.
module i2c_master_transaction_sequencer #(
  parameter int TX_DEPTH      = 16,
  parameter int RX_COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  i2cmts_pkg::in_t  in_word_i,
  output logic             empty,
  input  logic             pop,
  output i2cmts_pkg::out_t out_word_o
);

  logic                word_valid, word_pop;
  i2cmts_pkg::word_t   word;
  logic                bnd_push, bnd_full;
  i2cmts_pkg::bundle_t bnd;

  i2cmts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_word_i    (in_word_i),
    .word_valid_o (word_valid),
    .word_o       (word),
    .word_pop_i   (word_pop)
  );

  i2cmts_engine #(
    .TX_DEPTH      (TX_DEPTH),
    .RX_COUNT_BITS (RX_COUNT_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (word_valid),
    .word_i       (word),
    .word_pop_o   (word_pop),
    .bnd_push_o   (bnd_push),
    .bnd_o        (bnd),
    .bnd_full_i   (bnd_full)
  );

  i2cmts_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bnd_push_i (bnd_push),
    .bnd_i      (bnd),
    .bnd_full_o (bnd_full),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word_o)
  );

  // the rest of a run follows without a gap
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !out_word_o.last_of_run) |=> !empty)
    else $error("result run broken up");

  a_finish_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.finished) |-> out_word_o.last_of_run)
    else $error("finished result is not last of its run");

  a_success_needs_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_word_o.succeeded) |-> out_word_o.finished)
    else $error("succeeded without finished");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnd_push |-> (!bnd_full && (bnd.count != 2'd0)))
    else $error("bundle pushed into full queue or empty bundle");

endmodule

// ===== src/i2cmts_fifo.sv =====
// Two-entry register queue with push/full and pop/empty sides.
module i2cmts_fifo #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  T           mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/i2cmts_front.sv =====
// Input side: accepts words, drops unknown ops and reserved event codes, queues the rest for the engine.
module i2cmts_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  i2cmts_pkg::in_t   in_word_i,
  output logic              word_valid_o,
  output i2cmts_pkg::word_t word_o,
  input  logic              word_pop_i
);

  i2cmts_pkg::word_t cw;
  logic              keep;
  logic              q_empty;

  always_comb begin
    cw.kind      = i2cmts_pkg::K_EVENT;
    cw.data_byte = in_word_i.data_byte;
    cw.tx_slot   = in_word_i.tx_slot;
    cw.addr      = in_word_i.target_address;
    cw.ten       = in_word_i.ten_bit_mode;
    cw.wcount    = in_word_i.write_count;
    cw.rcount    = in_word_i.read_count;
    cw.evt       = in_word_i.event_code;
    keep         = 1'b0;
    unique case (in_word_i.op)
      i2cmts_pkg::OP_LOAD: begin
        cw.kind = i2cmts_pkg::K_LOAD;
        keep    = 1'b1;
      end
      i2cmts_pkg::OP_BEGIN: begin
        cw.kind = i2cmts_pkg::K_BEGIN;
        keep    = 1'b1;
      end
      i2cmts_pkg::OP_EVENT: begin
        // codes above rx ready are never waited for
        cw.kind = i2cmts_pkg::K_EVENT;
        keep    = (in_word_i.event_code <= i2cmts_pkg::EV_RX_READY);
      end
      default: keep = 1'b0;
    endcase
  end

  i2cmts_fifo #(.T(i2cmts_pkg::word_t)) u_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && keep),
    .data_i  (cw),
    .full_o  (full),
    .pop_i   (word_pop_i),
    .data_o  (word_o),
    .empty_o (q_empty)
  );

  assign word_valid_o = !q_empty;

endmodule

// ===== src/i2cmts_engine.sv =====
// Transaction state machine and transmit byte store; emits a bundle for each word that causes results.
module i2cmts_engine #(
  parameter int TX_DEPTH      = 16,
  parameter int RX_COUNT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                word_valid_i,
  input  i2cmts_pkg::word_t   word_i,
  output logic                word_pop_o,
  output logic                bnd_push_o,
  output i2cmts_pkg::bundle_t bnd_o,
  input  logic                bnd_full_i
);

  localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int PW = $clog2(TX_DEPTH + 1);
  localparam int RW = RX_COUNT_BITS;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_BUS,
    PH_WAIT_START,
    PH_WAIT_HDR,
    PH_WAIT_ADDR,
    PH_WAIT_TX,
    PH_RX
  } phase_e;

  phase_e          phase_q, phase_d;
  logic            rp_q, rp_d;
  logic [9:0]      addr_q, addr_d;
  logic            ten_q, ten_d;
  logic [PW-1:0]   wc_q, wc_d;
  logic [RW-1:0]   rc_q, rc_d;
  logic [PW-1:0]   wpos_q, wpos_d;
  logic [RW-1:0]   rpos_q, rpos_d;

  logic [7:0]      store_q [TX_DEPTH];
  logic [7:0]      tx_rd_q;
  logic            go, we;
  logic [AW-1:0]   waddr, raddr;
  logic [8:0]      slot_w;
  logic [31:0]     rc_w;
  logic [RW-1:0]   rpos_inc;
  logic [RW:0]     rpos_inc1;
  logic [1:0]      n;
  i2cmts_pkg::bundle_t bnd;

  function automatic i2cmts_pkg::out_t mk(input logic [2:0] c, input logic [7:0] b,
                                          input logic f, input logic s);
    i2cmts_pkg::out_t r;
    r.command      = c;
    r.command_byte = b;
    r.finished     = f;
    r.succeeded    = s;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign go         = word_valid_i && !bnd_full_i;
  assign word_pop_o = go;
  assign slot_w     = 9'(word_i.tx_slot);
  assign waddr      = slot_w[AW-1:0];
  assign we         = go && (word_i.kind == i2cmts_pkg::K_LOAD) &&
                      ({28'b0, word_i.tx_slot} < 32'(TX_DEPTH));
  assign rc_w       = 32'(word_i.rcount);
  assign rpos_inc   = rpos_q + 1'b1;
  assign rpos_inc1  = {1'b0, rpos_inc} + (RW + 1)'(1);
  // store is read at the position the next transmit will use
  assign raddr      = wpos_d[AW-1:0];

  always_comb begin
    phase_d = phase_q;
    rp_d    = rp_q;
    addr_d  = addr_q;
    ten_d   = ten_q;
    wc_d    = wc_q;
    rc_d    = rc_q;
    wpos_d  = wpos_q;
    rpos_d  = rpos_q;
    n       = 2'd0;
    bnd     = '0;

    if (go) begin
      unique case (word_i.kind)
        i2cmts_pkg::K_LOAD: begin
          n = 2'd0;
        end
        i2cmts_pkg::K_BEGIN: begin
          if (phase_q == PH_IDLE) begin
            addr_d = word_i.addr;
            ten_d  = word_i.ten;
            if ({27'b0, word_i.wcount} > 32'(TX_DEPTH)) begin
              wc_d = PW'(TX_DEPTH);
            end else begin
              wc_d = PW'(word_i.wcount);
            end
            rc_d    = rc_w[RW-1:0];
            wpos_d  = '0;
            rpos_d  = '0;
            rp_d    = 1'b0;
            phase_d = PH_WAIT_BUS;
          end
        end
        i2cmts_pkg::K_EVENT: begin
          unique case (phase_q)
            PH_WAIT_BUS: begin
              if (word_i.evt == i2cmts_pkg::EV_BUS_FREE) begin
                bnd.res[0] = mk(i2cmts_pkg::CMD_START, 8'd0, 1'b0, 1'b0);
                n          = 2'd1;
                phase_d    = PH_WAIT_START;
              end
            end
            PH_WAIT_START: begin
              if (word_i.evt == i2cmts_pkg::EV_START_SENT) begin
                n = 2'd1;
                if (ten_q) begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_WRITE,
                                  i2cmts_pkg::HDR_10 |
                                  {5'b0, addr_q[9:7] & i2cmts_pkg::HDR_HI_MASK} |
                                  {7'b0, rp_q}, 1'b0, 1'b0);
                  phase_d = PH_WAIT_HDR;
                end else begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_WRITE, {addr_q[6:0], rp_q}, 1'b0, 1'b0);
                  phase_d    = PH_WAIT_ADDR;
                end
              end
            end
            PH_WAIT_HDR: begin
              if (word_i.evt == i2cmts_pkg::EV_TX_EMPTY) begin
                bnd.res[0] = mk(i2cmts_pkg::CMD_WRITE, addr_q[7:0] & i2cmts_pkg::BYTE_MASK,
                                1'b0, 1'b0);
                n          = 2'd1;
                phase_d    = PH_WAIT_ADDR;
              end else if (word_i.evt == i2cmts_pkg::EV_ACK_FAILED) begin
                bnd.res[0] = mk(i2cmts_pkg::CMD_STOP, 8'd0, 1'b1, 1'b0);
                n          = 2'd1;
                phase_d    = PH_IDLE;
              end
            end
            PH_WAIT_ADDR: begin
              if (word_i.evt == i2cmts_pkg::EV_ADDR_ACKED) begin
                n = 2'd1;
                if (!rp_q) begin
                  if (wc_q != '0) begin
                    bnd.res[0] = mk(i2cmts_pkg::CMD_WRITE, tx_rd_q, 1'b0, 1'b0);
                    wpos_d     = PW'(1);
                    phase_d    = PH_WAIT_TX;
                  end else if (rc_q == '0) begin
                    bnd.res[0] = mk(i2cmts_pkg::CMD_STOP, 8'd0, 1'b1, 1'b1);
                    phase_d    = PH_IDLE;
                  end else begin
                    bnd.res[0] = mk(i2cmts_pkg::CMD_START, 8'd0, 1'b0, 1'b0);
                    rp_d       = 1'b1;
                    phase_d    = PH_WAIT_START;
                  end
                end else begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_ACK_ON, 8'd0, 1'b0, 1'b0);
                  rpos_d     = '0;
                  // single read byte: nack and stop are queued right away
                  if (rc_q == RW'(1)) begin
                    bnd.res[1] = mk(i2cmts_pkg::CMD_ACK_OFF, 8'd0, 1'b0, 1'b0);
                    bnd.res[2] = mk(i2cmts_pkg::CMD_STOP, 8'd0, 1'b0, 1'b0);
                    n          = 2'd3;
                  end
                  phase_d = PH_RX;
                end
              end else if (word_i.evt == i2cmts_pkg::EV_ACK_FAILED) begin
                bnd.res[0] = mk(i2cmts_pkg::CMD_STOP, 8'd0, 1'b1, 1'b0);
                n          = 2'd1;
                phase_d    = PH_IDLE;
              end
            end
            PH_WAIT_TX: begin
              if (word_i.evt == i2cmts_pkg::EV_TX_EMPTY) begin
                n = 2'd1;
                if (wpos_q < wc_q) begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_WRITE, tx_rd_q, 1'b0, 1'b0);
                  wpos_d     = wpos_q + 1'b1;
                end else if (rc_q == '0) begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_STOP, 8'd0, 1'b1, 1'b1);
                  phase_d    = PH_IDLE;
                end else begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_START, 8'd0, 1'b0, 1'b0);
                  rp_d       = 1'b1;
                  phase_d    = PH_WAIT_START;
                end
              end else if (word_i.evt == i2cmts_pkg::EV_ACK_FAILED) begin
                bnd.res[0] = mk(i2cmts_pkg::CMD_STOP, 8'd0, 1'b1, 1'b0);
                n          = 2'd1;
                phase_d    = PH_IDLE;
              end
            end
            PH_RX: begin
              if (word_i.evt == i2cmts_pkg::EV_RX_READY) begin
                rpos_d = rpos_inc;
                n      = 2'd1;
                if (rpos_inc >= rc_q) begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_RECV, word_i.data_byte, 1'b1, 1'b1);
                  phase_d    = PH_IDLE;
                end else begin
                  bnd.res[0] = mk(i2cmts_pkg::CMD_RECV, word_i.data_byte, 1'b0, 1'b0);
                  if (rpos_inc1 == {1'b0, rc_q}) begin
                    bnd.res[1] = mk(i2cmts_pkg::CMD_ACK_OFF, 8'd0, 1'b0, 1'b0);
                    bnd.res[2] = mk(i2cmts_pkg::CMD_STOP, 8'd0, 1'b0, 1'b0);
                    n          = 2'd3;
                  end
                end
              end
            end
            default: n = 2'd0;
          endcase
        end
        default: n = 2'd0;
      endcase
    end

    if (n != 2'd0) begin
      bnd.res[n - 2'd1].last_of_run = 1'b1;
    end
    bnd.count = n;
  end

  assign bnd_push_o = go && (n != 2'd0);
  assign bnd_o      = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rp_q    <= 1'b0;
      addr_q  <= '0;
      ten_q   <= 1'b0;
      wc_q    <= '0;
      rc_q    <= '0;
      wpos_q  <= '0;
      rpos_q  <= '0;
    end else begin
      phase_q <= phase_d;
      rp_q    <= rp_d;
      addr_q  <= addr_d;
      ten_q   <= ten_d;
      wc_q    <= wc_d;
      rc_q    <= rc_d;
      wpos_q  <= wpos_d;
      rpos_q  <= rpos_d;
    end
  end

  // one write and one registered read per cycle; a same-cycle load to the
  // read slot is forwarded
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= word_i.data_byte;
    end
    tx_rd_q <= (we && (waddr == raddr)) ? word_i.data_byte : store_q[raddr];
  end

endmodule

// ===== src/i2cmts_out.sv =====
// Result side: queues result bundles and presents them one word at a time.
module i2cmts_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                bnd_push_i,
  input  i2cmts_pkg::bundle_t bnd_i,
  output logic                bnd_full_o,
  output logic                empty,
  input  logic                pop,
  output i2cmts_pkg::out_t    out_word_o
);

  i2cmts_pkg::bundle_t head;
  logic [1:0]          idx_q, idx_d;
  logic                take, at_last;

  i2cmts_fifo #(.T(i2cmts_pkg::bundle_t)) u_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bnd_push_i),
    .data_i  (bnd_i),
    .full_o  (bnd_full_o),
    .pop_i   (take && at_last),
    .data_o  (head),
    .empty_o (empty)
  );

  assign take       = pop && !empty;
  assign at_last    = (idx_q == (head.count - 2'd1));
  assign out_word_o = head.res[idx_q];

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== verif/i2c_master_transaction_sequencer_test.sv =====
// Self-checking test of the I2C transaction sequencer: directed rows, then random sequences.
module i2c_master_transaction_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TX_SLOTS     = 16;
  localparam int RANDOM_WORDS = 130;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int PREDICTED    = -1;

  // codes the sequencer must ignore
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam logic [2:0] EV_RSVD_6  = 3'd6;
  localparam logic [2:0] EV_RSVD_7  = 3'd7;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_WAIT_BUS,
    SEQ_WAIT_START,
    SEQ_WAIT_HDR,
    SEQ_WAIT_ADDR,
    SEQ_WAIT_TX,
    SEQ_RX
  } seq_phase_e;

  typedef struct packed {
    i2cmts_pkg::in_t        w;
    logic                   typed;
    logic [1:0]             n;
    i2cmts_pkg::out_t [2:0] r;
  } dir_row_t;

  localparam i2cmts_pkg::out_t NO_CMD = '0;

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             push     = 1'b0;
  logic             full;
  i2cmts_pkg::in_t  in_word  = '0;
  logic             empty;
  logic             pop      = 1'b0;
  i2cmts_pkg::out_t out_word;

  // predictor state
  seq_phase_e  seq_phase = SEQ_IDLE;
  logic        rd_phase  = 1'b0;
  logic [9:0]  hold_addr = '0;
  logic        hold_ten  = 1'b0;
  logic [4:0]  hold_wc   = '0;
  logic [15:0] hold_rc   = '0;
  logic [4:0]  wr_pos    = '0;
  logic [15:0] rd_pos    = '0;
  logic [7:0]  tx_bytes [TX_SLOTS];

  i2cmts_pkg::out_t step_cmds [$];
  i2cmts_pkg::out_t pending_cmds [$];
  dir_row_t         dir_rows [$];
  int               fault_count = 0;
  bit               hold_req    = 1'b0;
  bit               hold_active = 1'b0;
  bit               steady      = 1'b0;

  i2c_master_transaction_sequencer dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .push      (push),
    .full      (full),
    .in_word_i (in_word),
    .empty     (empty),
    .pop       (pop),
    .out_word_o(out_word)
  );

  always #5ns clk = ~clk;

  function automatic void emit_cmd(logic [2:0] c, logic [7:0] b, logic fin, logic ok);
    i2cmts_pkg::out_t o;
    o = '{command: c, command_byte: b, finished: fin, succeeded: ok, last_of_run: 1'b0};
    step_cmds.push_back(o);
  endfunction

  function automatic void abort_on_nack();
    emit_cmd(i2cmts_pkg::CMD_STOP, 8'h00, 1'b1, 1'b0);
    seq_phase = SEQ_IDLE;
  endfunction

  // all writes sent: either done, or repeated start into the read half
  function automatic void close_writes();
    if (hold_rc == 16'd0) begin
      emit_cmd(i2cmts_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1);
      seq_phase = SEQ_IDLE;
    end else begin
      emit_cmd(i2cmts_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
      rd_phase  = 1'b1;
      seq_phase = SEQ_WAIT_START;
    end
  endfunction

  task automatic advance_sequencer(input i2cmts_pkg::in_t w, output bit effective);
    i2cmts_pkg::out_t tail;
    step_cmds.delete();
    effective = 1'b0;
    case (w.op)
      i2cmts_pkg::OP_LOAD: begin
        tx_bytes[w.tx_slot] = w.data_byte;
        effective = 1'b1;
      end
      i2cmts_pkg::OP_BEGIN: begin
        if (seq_phase == SEQ_IDLE) begin
          hold_addr = w.target_address;
          hold_ten  = w.ten_bit_mode;
          hold_wc   = (w.write_count > TX_SLOTS) ? 5'(TX_SLOTS) : w.write_count;
          hold_rc   = w.read_count;
          wr_pos    = '0;
          rd_pos    = '0;
          rd_phase  = 1'b0;
          seq_phase = SEQ_WAIT_BUS;
          effective = 1'b1;
        end
      end
      i2cmts_pkg::OP_EVENT: begin
        case (seq_phase)
          SEQ_WAIT_BUS: begin
            if (w.event_code == i2cmts_pkg::EV_BUS_FREE) begin
              emit_cmd(i2cmts_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
              seq_phase = SEQ_WAIT_START;
            end
          end
          SEQ_WAIT_START: begin
            if (w.event_code == i2cmts_pkg::EV_START_SENT) begin
              if (hold_ten) begin
                emit_cmd(i2cmts_pkg::CMD_WRITE, i2cmts_pkg::HDR_10
                         | {5'd0, hold_addr[9:7] & i2cmts_pkg::HDR_HI_MASK}
                         | {7'd0, rd_phase}, 1'b0, 1'b0);
                seq_phase = SEQ_WAIT_HDR;
              end else begin
                emit_cmd(i2cmts_pkg::CMD_WRITE, {hold_addr[6:0], rd_phase}, 1'b0, 1'b0);
                seq_phase = SEQ_WAIT_ADDR;
              end
            end
          end
          SEQ_WAIT_HDR: begin
            if (w.event_code == i2cmts_pkg::EV_TX_EMPTY) begin
              emit_cmd(i2cmts_pkg::CMD_WRITE, hold_addr[7:0], 1'b0, 1'b0);
              seq_phase = SEQ_WAIT_ADDR;
            end else if (w.event_code == i2cmts_pkg::EV_ACK_FAILED) begin
              abort_on_nack();
            end
          end
          SEQ_WAIT_ADDR: begin
            if (w.event_code == i2cmts_pkg::EV_ADDR_ACKED) begin
              if (!rd_phase) begin
                if (hold_wc > 0) begin
                  emit_cmd(i2cmts_pkg::CMD_WRITE, tx_bytes[0], 1'b0, 1'b0);
                  wr_pos    = 5'd1;
                  seq_phase = SEQ_WAIT_TX;
                end else begin
                  close_writes();
                end
              end else begin
                emit_cmd(i2cmts_pkg::CMD_ACK_ON, 8'h00, 1'b0, 1'b0);
                rd_pos = '0;
                if (hold_rc == 16'd1) begin
                  emit_cmd(i2cmts_pkg::CMD_ACK_OFF, 8'h00, 1'b0, 1'b0);
                  emit_cmd(i2cmts_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
                end
                seq_phase = SEQ_RX;
              end
            end else if (w.event_code == i2cmts_pkg::EV_ACK_FAILED) begin
              abort_on_nack();
            end
          end
          SEQ_WAIT_TX: begin
            if (w.event_code == i2cmts_pkg::EV_TX_EMPTY) begin
              if (wr_pos < hold_wc && wr_pos < TX_SLOTS) begin
                emit_cmd(i2cmts_pkg::CMD_WRITE, tx_bytes[wr_pos[3:0]], 1'b0, 1'b0);
                wr_pos = wr_pos + 5'd1;
              end else begin
                close_writes();
              end
            end else if (w.event_code == i2cmts_pkg::EV_ACK_FAILED) begin
              abort_on_nack();
            end
          end
          SEQ_RX: begin
            if (w.event_code == i2cmts_pkg::EV_RX_READY) begin
              rd_pos = rd_pos + 16'd1;
              if (rd_pos >= hold_rc) begin
                emit_cmd(i2cmts_pkg::CMD_RECV, w.data_byte, 1'b1, 1'b1);
                seq_phase = SEQ_IDLE;
              end else begin
                emit_cmd(i2cmts_pkg::CMD_RECV, w.data_byte, 1'b0, 1'b0);
                // next byte is the last one: nack it and stop
                if (({1'b0, rd_pos} + 17'd1) == {1'b0, hold_rc}) begin
                  emit_cmd(i2cmts_pkg::CMD_ACK_OFF, 8'h00, 1'b0, 1'b0);
                  emit_cmd(i2cmts_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0);
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (step_cmds.size() > 0) begin
      tail = step_cmds.pop_back();
      tail.last_of_run = 1'b1;
      step_cmds.push_back(tail);
      effective = 1'b1;
    end
  endtask

  function automatic i2cmts_pkg::in_t load_word(logic [3:0] slot, logic [7:0] b);
    i2cmts_pkg::in_t w;
    w = '0;
    w.op        = i2cmts_pkg::OP_LOAD;
    w.tx_slot   = slot;
    w.data_byte = b;
    return w;
  endfunction

  function automatic i2cmts_pkg::in_t begin_word(logic [9:0] a, logic ten, logic [4:0] wc,
                                                 logic [15:0] rc);
    i2cmts_pkg::in_t w;
    w = '0;
    w.op             = i2cmts_pkg::OP_BEGIN;
    w.target_address = a;
    w.ten_bit_mode   = ten;
    w.write_count    = wc;
    w.read_count     = rc;
    return w;
  endfunction

  function automatic i2cmts_pkg::in_t ev_word(logic [2:0] code, logic [7:0] b);
    i2cmts_pkg::in_t w;
    w = '0;
    w.op         = i2cmts_pkg::OP_EVENT;
    w.event_code = code;
    w.data_byte  = b;
    return w;
  endfunction

  function automatic i2cmts_pkg::out_t cmd(logic [2:0] c, logic [7:0] b, logic fin = 1'b0,
                                           logic ok = 1'b0, logic last = 1'b1);
    i2cmts_pkg::out_t o;
    o = '{command: c, command_byte: b, finished: fin, succeeded: ok, last_of_run: last};
    return o;
  endfunction

  function automatic dir_row_t row(i2cmts_pkg::in_t w, int n,
                                   i2cmts_pkg::out_t a = NO_CMD,
                                   i2cmts_pkg::out_t b = NO_CMD,
                                   i2cmts_pkg::out_t c = NO_CMD);
    dir_row_t d;
    d.w     = w;
    d.typed = (n != PREDICTED);
    d.n     = (n == PREDICTED) ? 2'd0 : 2'(n);
    d.r[0]  = a;
    d.r[1]  = b;
    d.r[2]  = c;
    return d;
  endfunction

  // mostly the event the current phase waits for, with stray words mixed in
  function automatic i2cmts_pkg::in_t pick_random_word();
    i2cmts_pkg::in_t w;
    int unsigned roll;
    int unsigned shape;
    w.op             = i2cmts_pkg::OP_EVENT;
    w.data_byte      = 8'($urandom);
    w.tx_slot        = 4'($urandom);
    w.target_address = 10'($urandom);
    w.ten_bit_mode   = 1'($urandom);
    w.write_count    = 5'($urandom);
    w.read_count     = 16'($urandom);
    w.event_code     = 3'($urandom);
    roll = $urandom_range(99, 0);
    if (roll < 8) begin
      w.op = i2cmts_pkg::OP_LOAD;
    end else if (roll < 10) begin
      w.op = OP_UNKNOWN;
    end else if (roll < 13) begin
      w.op = i2cmts_pkg::OP_BEGIN;
    end else if (roll < 20) begin
      w.op = i2cmts_pkg::OP_EVENT;
    end else if (seq_phase == SEQ_IDLE) begin
      w.op = i2cmts_pkg::OP_BEGIN;
      shape = $urandom_range(99, 0);
      if (shape < 70)      w.write_count = 5'($urandom_range(4, 0));
      else if (shape < 90) w.write_count = 5'($urandom_range(16, 5));
      else                 w.write_count = 5'($urandom_range(31, 17));
      shape = $urandom_range(99, 0);
      if (shape < 35)      w.read_count = 16'd0;
      else if (shape < 90) w.read_count = 16'($urandom_range(4, 1));
    end else begin
      case (seq_phase)
        SEQ_WAIT_BUS:   w.event_code = i2cmts_pkg::EV_BUS_FREE;
        SEQ_WAIT_START: w.event_code = i2cmts_pkg::EV_START_SENT;
        SEQ_WAIT_ADDR:  w.event_code = (rd_phase && hold_rc > 16'd8)
                                       ? i2cmts_pkg::EV_ACK_FAILED
                                       : i2cmts_pkg::EV_ADDR_ACKED;
        SEQ_RX:         w.event_code = i2cmts_pkg::EV_RX_READY;
        default:        w.event_code = i2cmts_pkg::EV_TX_EMPTY;
      endcase
      if ($urandom_range(99, 0) < 4) w.event_code = i2cmts_pkg::EV_ACK_FAILED;
    end
    return w;
  endfunction

  task automatic issue(input i2cmts_pkg::in_t w, input int n,
                       input i2cmts_pkg::out_t [2:0] typed, output bit effective);
    int unsigned roll;
    int unsigned gap;
    in_word <= w;
    push    <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    advance_sequencer(w, effective);
    if (n == PREDICTED) begin
      foreach (step_cmds[k]) pending_cmds.push_back(step_cmds[k]);
    end else begin
      for (int k = 0; k < n; k++) pending_cmds.push_back(typed[k]);
    end
    gap = 0;
    if (!steady && !hold_active) begin
      roll = $urandom_range(99, 0);
      if (roll >= 95)      gap = $urandom_range(30, 10);
      else if (roll >= 60) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endtask

  initial begin : stimulus
    i2cmts_pkg::in_t w;
    i2cmts_pkg::in_t odd;
    bit  eff;
    bit  paused;
    int  done_words;
    paused     = 1'b0;
    done_words = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole transmit store so no unwritten entry is ever sent
    for (int s = 0; s < TX_SLOTS; s++) begin
      issue(load_word(4'(s), (s == 0) ? 8'h00 : 8'($urandom)), PREDICTED, '0, eff);
    end

    odd    = '1;
    odd.op = OP_UNKNOWN;
    dir_rows.push_back(row(odd, 0));
    // 7-bit, max address, no data either way
    dir_rows.push_back(row(begin_word(10'h3FF, 1'b0, 5'd0, 16'd0), 0));
    dir_rows.push_back(row(ev_word(EV_RSVD_7, 8'h00), 0));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_BUS_FREE, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_START, 8'h00)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_START_SENT, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'hFE)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_ADDR_ACKED, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1)));
    // 10-bit, address zero, oversized write count, nack mid-write
    dir_rows.push_back(row(begin_word(10'h000, 1'b1, 5'd31, 16'hFFFF), 0));
    dir_rows.push_back(row(begin_word(10'h3FF, 1'b0, 5'd0, 16'd0), 0));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_BUS_FREE, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_START, 8'h00)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_START_SENT, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'hF0)));
    dir_rows.push_back(row(ev_word(EV_RSVD_6, 8'h00), 0));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_TX_EMPTY, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'h00)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_ADDR_ACKED, 8'h00), PREDICTED));
    dir_rows.push_back(row(load_word(4'd1, 8'hFF), 0));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_TX_EMPTY, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'hFF)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_ACK_FAILED, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_STOP, 8'h00, 1'b1, 1'b0)));
    // 10-bit, max address, single read byte after repeated start
    dir_rows.push_back(row(begin_word(10'h3FF, 1'b1, 5'd0, 16'd1), 0));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_BUS_FREE, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_START, 8'h00)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_START_SENT, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'hF6)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_TX_EMPTY, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'hFF)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_ADDR_ACKED, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_START, 8'h00)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_START_SENT, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'hF7)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_TX_EMPTY, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_WRITE, 8'hFF)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_ADDR_ACKED, 8'h00), 3,
                           cmd(i2cmts_pkg::CMD_ACK_ON, 8'h00, 1'b0, 1'b0, 1'b0),
                           cmd(i2cmts_pkg::CMD_ACK_OFF, 8'h00, 1'b0, 1'b0, 1'b0),
                           cmd(i2cmts_pkg::CMD_STOP, 8'h00)));
    dir_rows.push_back(row(ev_word(i2cmts_pkg::EV_RX_READY, 8'h00), 1,
                           cmd(i2cmts_pkg::CMD_RECV, 8'h00, 1'b1, 1'b1)));

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].w, dir_rows[i].typed ? int'(dir_rows[i].n) : PREDICTED,
            dir_rows[i].r, eff);
    end

    while (done_words < RANDOM_WORDS) begin
      if (done_words == 40) hold_req = 1'b1;
      steady = (done_words >= 70 && done_words < 95);
      if (done_words >= 120 && !paused) begin
        // let the result side run dry before going on
        paused = 1'b1;
        push <= 1'b0;
        do @(posedge clk); while (pending_cmds.size() != 0);
      end
      w = pick_random_word();
      issue(w, PREDICTED, '0, eff);
      done_words++;
    end

    push <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_cmds.size() == 0) begin
      $display("i2c_master_transaction_sequencer_test: done, clean");
    end else begin
      $display("i2c_master_transaction_sequencer_test: done, errors");
    end
    $finish;
  end

  initial begin : drain_results
    i2cmts_pkg::out_t want;
    int unsigned      roll;
    int               stall_left;
    int               hold_left;
    stall_left = 0;
    hold_left  = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_cmds.size() == 0) begin
          $error("result word with nothing expected: command %0d byte %0d",
                 out_word.command, out_word.command_byte);
          fault_count++;
        end else begin
          want = pending_cmds.pop_front();
          check_field("command", 8'(want.command), 8'(out_word.command));
          check_field("command_byte", want.command_byte, out_word.command_byte);
          check_field("finished", 8'(want.finished), 8'(out_word.finished));
          check_field("succeeded", 8'(want.succeeded), 8'(out_word.succeeded));
          check_field("last_of_run", 8'(want.last_of_run), 8'(out_word.last_of_run));
        end
      end
      if (hold_req && !hold_active && hold_left == 0 && stall_left >= 0) begin
        if (!steady && $urandom_range(0, 0) == 0 && hold_req) begin
          hold_left   = HOLD_CYCLES;
          hold_active = 1'b1;
          hold_req    = 1'b0;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_active = 1'b0;
        pop <= 1'b0;
      end else if (steady) begin
        pop <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop  <= 1'b1;
        roll = $urandom_range(99, 0);
        if (roll < 20)      stall_left = $urandom_range(3, 1);
        else if (roll < 24) stall_left = $urandom_range(40, 15);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("i2c_master_transaction_sequencer_test: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/i2cmts_pkg.sv
src/i2cmts_fifo.sv
src/i2cmts_front.sv
src/i2cmts_engine.sv
src/i2cmts_out.sv
src/i2c_master_transaction_sequencer.sv
verif/i2c_master_transaction_sequencer_test.sv
